### sv/direction_snap_with_hysteresis_macros.svh
// Assertion macros for the direction snap block.
// Used by the port checker; needs nothing else.
`ifndef DIRECTION_SNAP_WITH_HYSTERESIS_MACROS_SVH
`define DIRECTION_SNAP_WITH_HYSTERESIS_MACROS_SVH

// Same-cycle implication, off while reset is low.
`define DSH_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("dsh assertion failed");

// Next-cycle implication, off while reset is low.
`define DSH_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("dsh assertion failed");

`endif

### sv/dsh_pkg.sv
// Shared types, codes and column tables for the direction snap block.
// No dependencies.
`default_nettype none

package dsh_pkg;

    localparam int COMPONENT_WIDTH = 16;

    localparam logic [2:0] DIR_S  = 3'd0;
    localparam logic [2:0] DIR_SW = 3'd1;
    localparam logic [2:0] DIR_W  = 3'd2;
    localparam logic [2:0] DIR_NW = 3'd3;
    localparam logic [2:0] DIR_N  = 3'd4;
    localparam logic [2:0] DIR_NE = 3'd5;
    localparam logic [2:0] DIR_E  = 3'd6;
    localparam logic [2:0] DIR_SE = 3'd7;

    localparam logic [1:0] CNT_ONE   = 2'd0;
    localparam logic [1:0] CNT_FOUR  = 2'd1;
    localparam logic [1:0] CNT_EIGHT = 2'd2;

    localparam logic CFG_COUNT_MODE  = 1'b0;
    localparam logic CFG_UNIQUE_DIAG = 1'b1;

    localparam logic [19:0] CONE_SCALE = 20'd1000000;
    localparam logic [20:0] CONE_CARD  = 21'd786769;
    localparam logic [20:0] CONE_DIAG  = 21'd1573538;

    typedef struct packed {
        logic                              mode;
        logic signed [COMPONENT_WIDTH-1:0] dx;
        logic signed [COMPONENT_WIDTH-1:0] dy;
        logic [2:0]                        current_facing;
    } t_in_item;

    typedef struct packed {
        logic [2:0] direction;
        logic [2:0] column;
        logic       mirrored;
    } t_out_item;

    function automatic logic [2:0] four_col(input logic [2:0] dir);
        logic [2:0] col;
        unique case (dir)
            DIR_S, DIR_SW:  col = 3'd0;
            DIR_W, DIR_NW:  col = 3'd1;
            DIR_E, DIR_SE:  col = 3'd2;
            default:        col = 3'd3;
        endcase
        return col;
    endfunction

    function automatic logic [2:0] six_col(input logic [2:0] dir);
        logic [2:0] col;
        unique case (dir)
            DIR_S:          col = 3'd0;
            DIR_SW, DIR_SE: col = 3'd1;
            DIR_W:          col = 3'd2;
            DIR_NW, DIR_NE: col = 3'd3;
            DIR_N:          col = 3'd4;
            default:        col = 3'd5;
        endcase
        return col;
    endfunction

endpackage

`default_nettype wire

### sv/direction_snap_with_hysteresis.sv
// Direction snap with hysteresis: five-stage pipeline, top level.
// Depends on dsh_pkg.
//
//   channel  | handshake                     | payload
//   ---------+-------------------------------+---------------------------
//   input    | i_in_valid / o_in_stall       | i_in_item  (t_in_item)
//   output   | o_out_valid / i_out_stall     | o_out_item (t_out_item)
//   config   | i_cfg_valid / o_cfg_ready     | i_cfg_index, i_cfg_data
//
// One item per cycle while the output is not stalled; five register stages.
// The stages follow the cone test: square, scale by constant, compare.
// A stalled output holds the whole pipeline; bubbles do not collapse.
// Reset clears all valid bits and sets eight directions with distinct columns.
// Config writes are always ready.
`default_nettype none

module direction_snap_with_hysteresis
    import dsh_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire t_in_item   i_in_item,
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output t_out_item       o_out_item,
    input  wire logic       i_cfg_valid,
    output logic            o_cfg_ready,
    input  wire logic       i_cfg_index,
    input  wire logic [1:0] i_cfg_data
);

    localparam int CW = COMPONENT_WIDTH;
    localparam int PW = 2 * CW;
    localparam int LW = PW + 22;

    typedef struct packed {
        logic       mode;
        logic [2:0] cur;
        logic       dx_pos;
        logic       dy_pos;
        logic       zero;
        logic       ay_ge;
        logic       s_pos;
        logic [2:0] dir4;
    } t_tag;

    logic [1:0] r_count_mode;
    logic       r_unique_diag;

    logic       w_adv;
    logic [3:0] r_vld;
    logic       r_out_valid;
    t_out_item  r_out_item;

    // stage A
    t_tag            n_tag_a;
    logic [CW-1:0]   n_ax, n_ay, n_big, n_small, n_s_mag;
    logic signed [CW:0] n_s, w_dxe, w_dye;
    logic [CW+4:0]   w_ax20, w_ax23, w_ay20, w_ay23;
    t_tag            r_tag_a;
    logic [CW-1:0]   r_big, r_small, r_s_mag;

    // stage B
    t_tag            r_tag_b;
    logic [PW-1:0]   r_sm2, r_bg2, r_smbg, r_ss;

    // stage C
    logic [PW:0]     n_card_sum;
    t_tag            r_tag_c;
    logic            r_card;
    logic [PW:0]     r_len2;
    logic [LW-1:0]   r_lhs_c;

    // stage D
    logic [2:0]      n_oct;
    t_tag            r_tag_d;
    logic [2:0]      r_oct;
    logic [LW-1:0]   r_lhs, r_rhs;

    // output stage
    logic            w_eight;
    t_out_item       n_out;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count_mode  <= CNT_EIGHT;
            r_unique_diag <= 1'b1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_COUNT_MODE:  r_count_mode  <= i_cfg_data;
                CFG_UNIQUE_DIAG: r_unique_diag <= i_cfg_data[0];
            endcase
        end
    end

    assign w_adv      = !(r_out_valid && i_out_stall);
    assign o_in_stall = !w_adv;

    always_comb begin
        w_dxe = {i_in_item.dx[CW-1], i_in_item.dx};
        w_dye = {i_in_item.dy[CW-1], i_in_item.dy};
        n_ax  = i_in_item.dx[CW-1] ? (~i_in_item.dx + 1'b1) : i_in_item.dx;
        n_ay  = i_in_item.dy[CW-1] ? (~i_in_item.dy + 1'b1) : i_in_item.dy;

        n_tag_a.mode   = i_in_item.mode;
        n_tag_a.cur    = i_in_item.current_facing;
        n_tag_a.dx_pos = !i_in_item.dx[CW-1] && (i_in_item.dx != '0);
        n_tag_a.dy_pos = !i_in_item.dy[CW-1] && (i_in_item.dy != '0);
        n_tag_a.zero   = (i_in_item.dx == '0) && (i_in_item.dy == '0);
        n_tag_a.ay_ge  = (n_ay >= n_ax);
        n_big          = n_tag_a.ay_ge ? n_ay : n_ax;
        n_small        = n_tag_a.ay_ge ? n_ax : n_ay;

        unique case (i_in_item.current_facing)
            DIR_S:   n_s = w_dye;
            DIR_SW:  n_s = w_dye - w_dxe;
            DIR_W:   n_s = -w_dxe;
            DIR_NW:  n_s = -w_dxe - w_dye;
            DIR_N:   n_s = -w_dye;
            DIR_NE:  n_s = w_dxe - w_dye;
            DIR_E:   n_s = w_dxe;
            default: n_s = w_dxe + w_dye;
        endcase
        n_tag_a.s_pos = !n_s[CW] && (n_s != '0);
        n_s_mag       = n_s[CW-1:0];

        w_ax20 = {5'd0, n_ax} * (CW+5)'(20);
        w_ax23 = {5'd0, n_ax} * (CW+5)'(23);
        w_ay20 = {5'd0, n_ay} * (CW+5)'(20);
        w_ay23 = {5'd0, n_ay} * (CW+5)'(23);

        if (!i_in_item.mode) begin
            if (n_tag_a.ay_ge) begin
                n_tag_a.dir4 = n_tag_a.dy_pos ? DIR_S : DIR_N;
            end else begin
                n_tag_a.dir4 = n_tag_a.dx_pos ? DIR_E : DIR_W;
            end
        end else if (i_in_item.current_facing == DIR_E || i_in_item.current_facing == DIR_W) begin
            if (w_ay20 > w_ax23) begin
                n_tag_a.dir4 = n_tag_a.dy_pos ? DIR_S : DIR_N;
            end else begin
                n_tag_a.dir4 = n_tag_a.dx_pos ? DIR_E : DIR_W;
            end
        end else begin
            if (w_ax20 > w_ay23) begin
                n_tag_a.dir4 = n_tag_a.dx_pos ? DIR_E : DIR_W;
            end else begin
                n_tag_a.dir4 = n_tag_a.dy_pos ? DIR_S : DIR_N;
            end
        end
    end

    always_comb begin
        n_card_sum = {1'b0, r_sm2} + {r_smbg, 1'b0};
    end

    always_comb begin
        if (r_tag_c.zero) begin
            n_oct = DIR_S;
        end else if (r_card) begin
            if (r_tag_c.ay_ge) begin
                n_oct = r_tag_c.dy_pos ? DIR_S : DIR_N;
            end else begin
                n_oct = r_tag_c.dx_pos ? DIR_E : DIR_W;
            end
        end else if (r_tag_c.dy_pos) begin
            n_oct = r_tag_c.dx_pos ? DIR_SE : DIR_SW;
        end else begin
            n_oct = r_tag_c.dx_pos ? DIR_NE : DIR_NW;
        end
    end

    always_comb begin
        w_eight = r_count_mode[1];
        if (!w_eight) begin
            n_out.direction = r_tag_d.dir4;
        end else if (r_tag_d.mode
                     && (r_tag_d.zero || (r_tag_d.s_pos && r_lhs >= r_rhs))) begin
            n_out.direction = r_tag_d.cur;
        end else begin
            n_out.direction = r_oct;
        end

        n_out.mirrored = 1'b0;
        unique case (r_count_mode)
            CNT_ONE:  n_out.column = 3'd0;
            CNT_FOUR: n_out.column = four_col(n_out.direction);
            default: begin
                if (r_unique_diag) begin
                    n_out.column = n_out.direction;
                end else begin
                    n_out.column   = six_col(n_out.direction);
                    n_out.mirrored = (n_out.direction == DIR_NE)
                                     || (n_out.direction == DIR_SE);
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld       <= '0;
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_vld       <= {r_vld[2:0], i_in_valid};
            r_out_valid <= r_vld[3];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_tag_a   <= n_tag_a;
            r_big     <= n_big;
            r_small   <= n_small;
            r_s_mag   <= n_s_mag;

            r_tag_b   <= r_tag_a;
            r_sm2     <= PW'(r_small) * PW'(r_small);
            r_bg2     <= PW'(r_big) * PW'(r_big);
            r_smbg    <= PW'(r_small) * PW'(r_big);
            r_ss      <= PW'(r_s_mag) * PW'(r_s_mag);

            r_tag_c   <= r_tag_b;
            r_card    <= (n_card_sum < {1'b0, r_bg2});
            r_len2    <= {1'b0, r_sm2} + {1'b0, r_bg2};
            r_lhs_c   <= LW'(r_ss) * LW'(CONE_SCALE);

            r_tag_d   <= r_tag_c;
            r_oct     <= n_oct;
            r_lhs     <= r_lhs_c;
            r_rhs     <= LW'(r_len2) * LW'(r_tag_c.cur[0] ? CONE_DIAG : CONE_CARD);

            r_out_item <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

`default_nettype wire

### sv/dsh_checker.sv
// Port-level checker for the direction snap block, bound to the top level.
// Depends on dsh_pkg and direction_snap_with_hysteresis_macros.svh.
`default_nettype none
`include "direction_snap_with_hysteresis_macros.svh"

module dsh_checker
    import dsh_pkg::*;
(
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       o_in_stall,
    input wire logic       o_out_valid,
    input wire logic       i_out_stall,
    input wire t_out_item  o_out_item
);

    logic w_out_hold;
    logic w_mir_diag;
    logic w_mir_col;

    assign w_out_hold = o_out_valid && i_out_stall;
    assign w_mir_diag = (o_out_item.direction == DIR_NE) || (o_out_item.direction == DIR_SE);
    assign w_mir_col  = (o_out_item.column == 3'd1) || (o_out_item.column == 3'd3);

    `DSH_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, w_out_hold,
        o_out_valid && $stable(o_out_item))
    `DSH_ASSERT_NOW(a_stall_cause, i_clk, i_rst_n, o_in_stall, w_out_hold)
    `DSH_ASSERT_NOW(a_mirror_diag, i_clk, i_rst_n, o_out_valid && o_out_item.mirrored,
        w_mir_diag && w_mir_col)

endmodule

bind direction_snap_with_hysteresis dsh_checker u_dsh_checker (.*);

`default_nettype wire
